// ===== rtl/playfair_digraph_cipher_assert.svh =====
// Assertion macros for the Playfair digraph cipher checker.
// Self-contained; included by the checker file only.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH

// Check an implication in the same cycle, off while reset is asserted
`define PDC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the next cycle, off while reset is asserted
`define PDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Check an implication in the next cycle, active during reset as well
`define PDC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pdc_pkg.sv =====
// Shared types, constants and lookup functions for the Playfair digraph cipher.
// No dependencies.
package pdc_pkg;

    localparam int SIDE       = 5;
    localparam int LETTER_W   = 5;
    localparam int ROW_W      = SIDE * LETTER_W;
    localparam int POS_W      = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int CFG_IDX_W  = 3;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [ROW_W-1:0]    t_row;
    typedef t_row [SIDE-1:0]     t_square;

    localparam t_letter LETTER_X = 5'd23;
    localparam t_letter LETTER_J = 5'd9;
    localparam t_letter LETTER_I = 5'd8;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECRYPT = 3'd0,
        CFG_ROW0    = 3'd1,
        CFG_ROW1    = 3'd2,
        CFG_ROW2    = 3'd3,
        CFG_ROW3    = 3'd4,
        CFG_ROW4    = 3'd5
    } t_cfg_idx;

    // Reset square: the alphabet without j, row-major
    localparam t_row ROW0_RST = 25'd4294688;
    localparam t_row ROW1_RST = 25'd10755269;
    localparam t_row ROW2_RST = 25'd16201099;
    localparam t_row ROW3_RST = 25'd21613104;
    localparam t_row ROW4_RST = 25'd27025109;

    typedef struct packed {
        t_letter a;
        t_letter b;
        logic    fin;
    } t_pair;

    typedef struct packed {
        t_pos row;
        t_pos col;
    } t_loc;

    typedef struct packed {
        t_letter first;
        t_letter second;
    } t_result;

    // Find a letter in the square, j folded to i; first hit in row-major
    // order wins, a miss lands at row 0, column 0
    function automatic t_loc f_locate(t_square sq, t_letter code);
        t_letter key;
        t_loc    loc;
        key = (code == LETTER_J) ? LETTER_I : code;
        loc = '0;
        for (int r = SIDE - 1; r >= 0; r--) begin
            for (int c = SIDE - 1; c >= 0; c--) begin
                if (sq[r][c*LETTER_W +: LETTER_W] == key) begin
                    loc.row = POS_W'(r);
                    loc.col = POS_W'(c);
                end
            end
        end
        return loc;
    endfunction

    // Read one cell of the square
    function automatic t_letter f_cell(t_square sq, t_pos row, t_pos col);
        t_letter res;
        t_row    line;
        res  = '0;
        line = '0;
        for (int r = 0; r < SIDE; r++) begin
            if (POS_W'(r) == row) begin
                line = sq[r];
            end
        end
        for (int c = 0; c < SIDE; c++) begin
            if (POS_W'(c) == col) begin
                res = line[c*LETTER_W +: LETTER_W];
            end
        end
        return res;
    endfunction

    // Step one place around the square: +1 to encrypt, -1 (that is +4) to decrypt
    function automatic t_pos f_wrap(t_pos pos, logic dec);
        logic [POS_W:0] sum;
        sum = {1'b0, pos} + (dec ? (POS_W+1)'(SIDE - 1) : (POS_W+1)'(1));
        if (sum >= (POS_W+1)'(SIDE)) begin
            sum = sum - (POS_W+1)'(SIDE);
        end
        return sum[POS_W-1:0];
    endfunction

    // Apply the Playfair rule to one digraph
    function automatic t_result f_cipher(t_square sq, logic dec, t_letter a, t_letter b);
        t_loc    l0;
        t_loc    l1;
        t_result res;
        l0 = f_locate(sq, a);
        l1 = f_locate(sq, b);
        if (l0.row == l1.row) begin
            res.first  = f_cell(sq, l0.row, f_wrap(l0.col, dec));
            res.second = f_cell(sq, l0.row, f_wrap(l1.col, dec));
        end else if (l0.col == l1.col) begin
            res.first  = f_cell(sq, f_wrap(l0.row, dec), l0.col);
            res.second = f_cell(sq, f_wrap(l1.row, dec), l0.col);
        end else begin
            res.first  = f_cell(sq, l0.row, l1.col);
            res.second = f_cell(sq, l1.row, l0.col);
        end
        return res;
    endfunction

endpackage

// ===== rtl/playfair_digraph_cipher.sv =====
// Playfair digraph cipher: pairs a letter stream into digraphs and ciphers them; uses pdc_pkg.
// Throughput: one letter word per cycle while o_s_tready is high; a doubled final letter gives two words.
// The digraph that a letter completes is written into the pair queue at the edge that accepts it;
// the queue head is ciphered into the output register once that register is free.
// Reset (synchronous, active low) clears the held letter, the pair queue, the
// output valid flag, and restores encrypt mode and the alphabet square.
module playfair_digraph_cipher (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input letters
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // [4:0] letter
    input  logic                          i_s_tlast,   // end_of_message
    // Cipher digraphs
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [15:0]                   o_m_tdata,   // [4:0] first_out, [9:5] second_out
    output logic                          o_m_tlast,   // final_pair
    // Configuration writes
    input  logic                          i_cfg_we,
    input  logic [pdc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pdc_pkg::ROW_W-1:0]     i_cfg_data
);
    import pdc_pkg::*;

    logic               r_decrypt;
    t_square            r_square;
    logic               r_held_valid;
    t_letter            r_held_letter;
    logic               n_held_valid;
    t_letter            n_held_letter;

    t_pair              r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    logic               r_m_valid;
    logic               n_m_valid;
    t_result            r_m_res;
    logic               r_m_last;

    logic               s_acc;
    logic               pop;
    logic [1:0]         push_cnt;
    t_pair              pair0;
    t_pair              pair1;
    t_letter            in_letter;
    t_result            head_res;

    assign in_letter  = i_s_tdata[LETTER_W-1:0];
    assign o_s_tready = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign pop        = (r_count != '0) && (!r_m_valid || i_m_tready);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt   <= 1'b0;
            r_square[0] <= ROW0_RST;
            r_square[1] <= ROW1_RST;
            r_square[2] <= ROW2_RST;
            r_square[3] <= ROW3_RST;
            r_square[4] <= ROW4_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DECRYPT: r_decrypt   <= i_cfg_data[0];
                CFG_ROW0:    r_square[0] <= i_cfg_data;
                CFG_ROW1:    r_square[1] <= i_cfg_data;
                CFG_ROW2:    r_square[2] <= i_cfg_data;
                CFG_ROW3:    r_square[3] <= i_cfg_data;
                CFG_ROW4:    r_square[4] <= i_cfg_data;
                default:     r_decrypt   <= r_decrypt;
            endcase
        end
    end

    // Pair incoming letters; insert x between doubles and after a lone last letter
    always_comb begin
        push_cnt      = 2'd0;
        pair0         = '0;
        pair1         = '0;
        n_held_valid  = r_held_valid;
        n_held_letter = r_held_letter;
        if (s_acc) begin
            if (!r_held_valid) begin
                if (i_s_tlast) begin
                    pair0    = '{a: in_letter, b: LETTER_X, fin: 1'b1};
                    push_cnt = 2'd1;
                end else begin
                    n_held_valid  = 1'b1;
                    n_held_letter = in_letter;
                end
            end else if (r_held_letter != in_letter) begin
                pair0         = '{a: r_held_letter, b: in_letter, fin: i_s_tlast};
                push_cnt      = 2'd1;
                n_held_valid  = 1'b0;
                n_held_letter = '0;
            end else begin
                pair0    = '{a: r_held_letter, b: LETTER_X, fin: 1'b0};
                push_cnt = 2'd1;
                if (i_s_tlast) begin
                    pair1         = '{a: in_letter, b: LETTER_X, fin: 1'b1};
                    push_cnt      = 2'd2;
                    n_held_valid  = 1'b0;
                    n_held_letter = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid  <= 1'b0;
            r_held_letter <= '0;
        end else begin
            r_held_valid  <= n_held_valid;
            r_held_letter <= n_held_letter;
        end
    end

    // Pair queue: push up to two digraphs, pop one per cycle while the output register is free
    assign n_count = r_count + CNT_W'(push_cnt) - CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + PTR_W'(push_cnt);
            r_rptr  <= r_rptr + PTR_W'(pop);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_fifo[r_wptr] <= pair0;
        end
        if (push_cnt == 2'd2) begin
            r_fifo[r_wptr + PTR_W'(1)] <= pair1;
        end
    end

    // Cipher the queue head into the output register
    assign head_res  = f_cipher(r_square, r_decrypt, r_fifo[r_rptr].a, r_fifo[r_rptr].b);
    assign n_m_valid = pop ? 1'b1 : (i_m_tready ? 1'b0 : r_m_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_m_res  <= head_res;
            r_m_last <= r_fifo[r_rptr].fin;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {6'd0, r_m_res.second, r_m_res.first};
    assign o_m_tlast  = r_m_last;

endmodule

// ===== rtl/pdc_checker.sv =====
// Port-level checker for the Playfair digraph cipher, bound to the top level.
// Depends on playfair_digraph_cipher_assert.svh.
`include "playfair_digraph_cipher_assert.svh"

module pdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tlast
);

    // A stalled output word holds
    `PDC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast), "output word changed while stalled")

    // Reset leaves no output word and an open input
    `PDC_ASSERT_NEXT_ALWAYS(a_reset_clear, i_clk, !i_rst_n, !o_m_tvalid && o_s_tready, "reset did not clear the pipeline")

    // Input back-pressure only arises with a word waiting at the output
    `PDC_ASSERT_NOW(a_bp_has_word, i_clk, i_rst_n, !o_s_tready, o_m_tvalid, "input stalled with no output word")

    // Pair queue drains one word per cycle once the output is taken
    `PDC_ASSERT_NEXT(a_bp_release, i_clk, i_rst_n, !o_s_tready && i_m_tready, o_m_tvalid, "queue did not refill the output")

endmodule

bind playfair_digraph_cipher pdc_checker u_pdc_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking bench for playfair_digraph_cipher: streams letter messages through
// the cipher under several key squares and both directions, predicting every digraph.
// Depends on pdc_pkg and the playfair_digraph_cipher RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pdc_pkg::*;

    // Index codes past the last register; writes to them must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam t_row ROW_ALL_ONES = 25'h1FFFFFF;
    localparam int   RESULT_LATENCY = 8;
    localparam int   STALL_TRIGGER  = 180;
    localparam int   STALL_BACKLOG  = 16;
    localparam int   STALL_CYCLES   = 300;
    localparam int   PHASE_LETTERS  = 65;

    typedef struct packed {
        t_letter ltr;
        logic    last;
    } t_letter_word;

    typedef struct packed {
        t_letter first;
        t_letter second;
        logic    fin;
    } t_digraph;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    // Letter side
    logic       s_valid = 1'b0;
    logic [7:0] s_data  = '0;
    logic       s_last  = 1'b0;
    logic       o_s_tready;

    // Digraph side
    logic        m_ready = 1'b0;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;
    logic        o_m_tlast;

    // Register writes
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    t_row                 cfg_data = '0;

    // Predictor state: cipher settings and the letter waiting for a partner
    logic    decrypt_on = 1'b0;
    t_row    key_rows [SIDE] = '{ROW0_RST, ROW1_RST, ROW2_RST, ROW3_RST, ROW4_RST};
    logic    held_on  = 1'b0;
    t_letter held_ltr = '0;

    t_letter_word letters_to_send [$];
    t_digraph     owed_digraphs [$];
    t_letter_word next_word;

    int letters_sent  = 0;
    int letters_taken = 0;
    int err_count     = 0;
    int tx_wait       = 0;
    int tx_calm       = 0;
    int rx_wait       = 0;
    int rx_left       = 0;
    int rx_calm       = 0;
    int stall_left    = 0;
    bit stall_done    = 1'b0;

    playfair_digraph_cipher i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),
        .i_s_tlast  (s_last),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= 100) begin
            $display("%0t: %s: got %0d, want %0d", $realtime, what, got, want);
        end
    endtask

    // Idle cycles before the next word; now and then a calm stretch with none
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic t_letter square_at(input int row, input int col);
        return key_rows[row][col*LETTER_W +: LETTER_W];
    endfunction

    // First cell in row-major order holding the letter (j read as i); a miss is the corner
    function automatic void find_letter(input t_letter code, output int row, output int col);
        t_letter key;
        bit      found;
        key   = (code == LETTER_J) ? LETTER_I : code;
        found = 1'b0;
        row   = 0;
        col   = 0;
        for (int r = 0; r < SIDE; r++) begin
            for (int c = 0; c < SIDE; c++) begin
                if (!found && square_at(r, c) == key) begin
                    found = 1'b1;
                    row   = r;
                    col   = c;
                end
            end
        end
    endfunction

    // Cipher one digraph and add it to the owed words
    function automatic void encipher_digraph(input t_letter a, input t_letter b,
                                             input logic fin);
        int       r0, c0, r1, c1, shift;
        t_digraph d;
        shift = decrypt_on ? SIDE - 1 : 1;
        find_letter(a, r0, c0);
        find_letter(b, r1, c1);
        if (r0 == r1) begin
            d.first  = square_at(r0, (c0 + shift) % SIDE);
            d.second = square_at(r0, (c1 + shift) % SIDE);
        end else if (c0 == c1) begin
            d.first  = square_at((r0 + shift) % SIDE, c0);
            d.second = square_at((r1 + shift) % SIDE, c0);
        end else begin
            d.first  = square_at(r0, c1);
            d.second = square_at(r1, c0);
        end
        d.fin = fin;
        owed_digraphs.insert(owed_digraphs.size(), d);
    endfunction

    // Pair an accepted letter with the held one, padding doubles and lone endings with x
    function automatic void pair_letter(input t_letter ltr, input logic last);
        if (!held_on) begin
            if (last) begin
                encipher_digraph(ltr, LETTER_X, 1'b1);
            end else begin
                held_on  = 1'b1;
                held_ltr = ltr;
            end
        end else if (held_ltr != ltr) begin
            encipher_digraph(held_ltr, ltr, last);
            held_on = 1'b0;
        end else begin
            encipher_digraph(held_ltr, LETTER_X, 1'b0);
            if (last) begin
                encipher_digraph(ltr, LETTER_X, 1'b1);
                held_on = 1'b0;
            end
        end
    endfunction

    // Offer letter words, honoring the drawn gap before each
    always @(posedge i_clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_tready) begin
                pair_letter(s_data[LETTER_W-1:0], s_last);
                letters_taken <= letters_taken + 1;
            end
            if (!s_valid || o_s_tready) begin
                if (tx_wait != 0) begin
                    s_valid <= 1'b0;
                    tx_wait <= tx_wait - 1;
                end else if (letters_to_send.size() != 0) begin
                    next_word = letters_to_send.pop_front();
                    s_valid   <= 1'b1;
                    s_data    <= {3'b000, next_word.ltr};
                    s_last    <= next_word.last;
                    tx_wait   <= draw_gap(tx_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Take digraph words and compare them with the oldest owed one
    always @(posedge i_clk) begin
        if (!rst_n) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else begin
            rx_left = rx_wait;
            if (m_ready && o_m_tvalid) begin
                if (owed_digraphs.size() == 0) begin
                    report_mismatch("unexpected digraph word, first", o_m_tdata[4:0], 0);
                end else begin
                    if (o_m_tdata[4:0] != owed_digraphs[0].first)
                        report_mismatch("first_out", o_m_tdata[4:0], owed_digraphs[0].first);
                    if (o_m_tdata[9:5] != owed_digraphs[0].second)
                        report_mismatch("second_out", o_m_tdata[9:5], owed_digraphs[0].second);
                    if (o_m_tlast != owed_digraphs[0].fin)
                        report_mismatch("final_pair", o_m_tlast, owed_digraphs[0].fin);
                    void'(owed_digraphs.pop_front());
                end
                rx_left = draw_gap(rx_calm);
            end else if (rx_left != 0) begin
                rx_left--;
            end
            rx_wait <= rx_left;
            m_ready <= (rx_left == 0) && (stall_left == 0);
        end
    end

    // Hold the digraph side off once for a long stretch so the letter side backs up;
    // start it only with enough letters still queued to fill the block
    always @(posedge i_clk) begin
        if (!rst_n) begin
            stall_left <= 0;
        end else if (!stall_done && letters_taken >= STALL_TRIGGER &&
                     letters_to_send.size() >= STALL_BACKLOG) begin
            stall_left <= STALL_CYCLES;
            stall_done <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    function automatic void queue_letter(input t_letter ltr, input logic last);
        t_letter_word w;
        w.ltr  = ltr;
        w.last = last;
        letters_to_send.insert(letters_to_send.size(), w);
        letters_sent++;
    endfunction

    // Write one register while idle and mirror it in the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_row val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        if (idx == CFG_DECRYPT) begin
            decrypt_on = val[0];
        end else if (idx <= CFG_ROW4) begin
            key_rows[idx - CFG_ROW0] = val;
        end
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Load a proper square: the alphabet without j, shuffled or in order
    task automatic load_square(input bit shuffle);
        t_letter codes [SIDE*SIDE];
        t_letter tmp;
        t_row    row_val;
        int      m;
        for (int k = 0; k < SIDE * SIDE; k++) begin
            codes[k] = (k >= LETTER_J) ? LETTER_W'(k + 1) : LETTER_W'(k);
        end
        if (shuffle) begin
            for (int k = SIDE * SIDE - 1; k > 0; k--) begin
                m        = $urandom_range(0, k);
                tmp      = codes[k];
                codes[k] = codes[m];
                codes[m] = tmp;
            end
        end
        for (int r = 0; r < SIDE; r++) begin
            row_val = '0;
            for (int c = 0; c < SIDE; c++) begin
                row_val[c*LETTER_W +: LETTER_W] = codes[r*SIDE + c];
            end
            write_reg(CFG_IDX_W'(int'(CFG_ROW0) + r), row_val);
        end
    endtask

    task automatic fill_rows(input t_row val);
        for (int r = 0; r < SIDE; r++) begin
            write_reg(CFG_IDX_W'(int'(CFG_ROW0) + r), val);
        end
    endtask

    // Random messages, biased toward doubled letters, i/j and x
    task automatic queue_messages(input int count);
        int      queued;
        int      len;
        t_letter prev;
        t_letter ltr;
        queued = 0;
        while (queued < count) begin
            len  = ($urandom_range(0, 9) == 0) ? 1 : int'($urandom_range(2, 14));
            prev = LETTER_W'($urandom_range(0, 25));
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(0, 9))
                    0, 1:    ltr = prev;
                    2:       ltr = $urandom_range(0, 1) ? LETTER_I : LETTER_J;
                    3:       ltr = LETTER_X;
                    default: ltr = LETTER_W'($urandom_range(0, 25));
                endcase
                queue_letter(ltr, k == len - 1);
                prev = ltr;
            end
            queued += len;
        end
    endtask

    // Wait until every letter is in and every owed digraph is out, then let the pipe settle
    task automatic drain();
        do begin
            @(posedge i_clk);
        end while (letters_taken != letters_sent || owed_digraphs.size() != 0);
        repeat (RESULT_LATENCY) @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;

        // Directed: row, column and rectangle pairs, i/j together, doubles, lone endings
        queue_letter(5'd0, 1'b0);  queue_letter(5'd1, 1'b0);
        queue_letter(5'd0, 1'b0);  queue_letter(5'd5, 1'b0);
        queue_letter(5'd0, 1'b0);  queue_letter(5'd25, 1'b0);
        queue_letter(LETTER_I, 1'b0); queue_letter(LETTER_J, 1'b0);
        queue_letter(LETTER_J, 1'b0); queue_letter(LETTER_I, 1'b0);
        queue_letter(LETTER_X, 1'b0); queue_letter(LETTER_X, 1'b0);
        queue_letter(5'd25, 1'b1);
        queue_letter(5'd11, 1'b0); queue_letter(5'd11, 1'b0); queue_letter(5'd11, 1'b1);
        queue_letter(5'd16, 1'b1);
        queue_letter(LETTER_J, 1'b1);
        queue_letter(5'd4, 1'b0);  queue_letter(5'd4, 1'b0);  queue_letter(5'd4, 1'b1);
        queue_letter(5'd4, 1'b0);  queue_letter(5'd0, 1'b1);
        drain();

        // Keyed square, decrypt
        load_square(1'b1);
        write_reg(CFG_DECRYPT, 25'd1);
        queue_messages(PHASE_LETTERS);
        drain();

        // Another keyed square, encrypt; the bits above bit 0 must be dropped
        load_square(1'b1);
        write_reg(CFG_DECRYPT, ROW_ALL_ONES - 25'd1);
        queue_messages(PHASE_LETTERS);
        drain();

        // Improper random square; writes past the last register change nothing
        for (int r = 0; r < SIDE; r++) begin
            write_reg(CFG_IDX_W'(int'(CFG_ROW0) + r), t_row'($urandom));
        end
        write_reg(CFG_DECRYPT, t_row'($urandom_range(0, 1)));
        write_reg(CFG_SPARE_LO, ROW_ALL_ONES);
        write_reg(CFG_SPARE_HI, '0);
        queue_messages(PHASE_LETTERS);
        drain();

        // All-zero square, encrypt
        fill_rows('0);
        write_reg(CFG_DECRYPT, '0);
        queue_messages(PHASE_LETTERS);
        drain();

        // All-ones square: no letter found anywhere; decrypt
        fill_rows(ROW_ALL_ONES);
        write_reg(CFG_DECRYPT, ROW_ALL_ONES);
        queue_messages(PHASE_LETTERS);
        drain();

        // Plain alphabet square, decrypt
        load_square(1'b0);
        write_reg(CFG_DECRYPT, 25'd1);
        queue_messages(PHASE_LETTERS);
        drain();

        if (err_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // Hang guard, many times the slowest correct run
    initial begin
        #1_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pdc_pkg.sv
rtl/playfair_digraph_cipher.sv
rtl/pdc_checker.sv
tb/testbench.sv
